>>> src/rrf_pkg.sv
// ============================================================================
// rrf_pkg
// Shared types and codes for the request framer: parser phases, byte roles,
// error codes, command classes and protocol characters.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package rrf_pkg;

  // parser phase
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_CNT_TXT,
    PH_CNT_CR,
    PH_DOLLAR,
    PH_LEN_TXT,
    PH_LEN_CR,
    PH_PAYLOAD,
    PH_PAY_CR,
    PH_PAY_LF
  } phase_t;

  // byte roles
  localparam logic [2:0] ROLE_ARRAY   = 3'd0;
  localparam logic [2:0] ROLE_COUNT   = 3'd1;
  localparam logic [2:0] ROLE_DOLLAR  = 3'd2;
  localparam logic [2:0] ROLE_LENGTH  = 3'd3;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd4;
  localparam logic [2:0] ROLE_CRLF    = 3'd5;
  localparam logic [2:0] ROLE_DISCARD = 3'd6;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_STAR  = 3'd1;
  localparam logic [2:0] ERR_NO_DOLLAR = 3'd2;
  localparam logic [2:0] ERR_NO_CRLF  = 3'd3;
  localparam logic [2:0] ERR_NUMBER   = 3'd4;

  // command classes
  localparam logic [2:0] CLASS_OTHER   = 3'd0;
  localparam logic [2:0] CLASS_WRITE   = 3'd1;
  localparam logic [2:0] CLASS_PING    = 3'd2;
  localparam logic [2:0] CLASS_SYNC    = 3'd3;
  localparam logic [2:0] CLASS_CONNECT = 3'd4;

  // twelve-byte connect command name, first character in the top byte
  localparam logic [95:0] CONNECT_WORD = 96'h52444d415f434f4e4e454354;

  // protocol characters
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7a;
  localparam logic [7:0] CASE_BIT  = 8'h20;

endpackage

`default_nettype wire

>>> src/rrf_classify.sv
// ============================================================================
// rrf_classify
// Case-insensitive match of the stored first argument against the known
// command names; gives the command class.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rrf_classify #(
  parameter int NAME_BYTES = 12,
  parameter int LEN_BITS   = 31
) (
  input  wire logic [NAME_BYTES-1:0][7:0] name,
  input  wire logic [LEN_BITS-1:0]        name_len,
  output logic [2:0]                      cmd_class
);
  import rrf_pkg::*;

  logic [NAME_BYTES-1:0][7:0] up;
  logic [23:0] w3;
  logic [23:0] tail3;
  logic [31:0] w4;
  logic [95:0] w12;
  logic        len3;
  logic        len4;
  logic        len12;
  logic        base3;
  logic        tail_op;
  logic        pfx;

  // fold lower case letters to upper case
  always_comb begin
    for (int i = 0; i < NAME_BYTES; i++) begin
      up[i] = name[i];
      if (name[i] >= CH_LOW_A && name[i] <= CH_LOW_Z) begin
        up[i] = name[i] & ~CASE_BIT;
      end
    end
  end

  assign w3    = {up[0], up[1], up[2]};
  assign tail3 = {up[1], up[2], up[3]};
  assign w4    = {up[0], up[1], up[2], up[3]};
  assign w12   = {up[0], up[1], up[2], up[3], up[4], up[5],
                  up[6], up[7], up[8], up[9], up[10], up[11]};

  assign len3  = (name_len == LEN_BITS'(3));
  assign len4  = (name_len == LEN_BITS'(4));
  assign len12 = (name_len == LEN_BITS'(12));

  assign base3   = (w3 == "SET") || (w3 == "DEL") || (w3 == "MOD");
  assign tail_op = (tail3 == "SET") || (tail3 == "DEL") || (tail3 == "MOD");
  assign pfx     = (up[0] == "R") || (up[0] == "H") || (up[0] == "S");

  // priority follows the write list first, then the named commands
  always_comb begin
    cmd_class = CLASS_OTHER;
    if ((len3 && base3) || (len4 && pfx && tail_op)) begin
      cmd_class = CLASS_WRITE;
    end else if (len4 && w4 == "PING") begin
      cmd_class = CLASS_PING;
    end else if (len4 && w4 == "SYNC") begin
      cmd_class = CLASS_SYNC;
    end else if (len12 && w12 == CONNECT_WORD) begin
      cmd_class = CLASS_CONNECT;
    end
  end

endmodule

`default_nettype wire

>>> src/resp_request_framer_core.sv
// ============================================================================
// resp_request_framer_core
// Frames RESP arrays of bulk strings from a byte stream and tags every byte
// with its role, argument index, running count and end marks.
// ============================================================================
// Path: an accepted word is held in the input register, then registered onto the result port.
// Throughput: one byte per cycle while the result port is not stalled; the parser state
// update is combinational logic between the input register and the result register.
// Reset: synchronous, clears the parser to waiting for '*' and empties both
// registers; the first-argument name store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module resp_request_framer_core #(
  parameter int NAME_BYTES = 12,
  parameter int COUNT_BITS = 31
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       byte_role,
  output logic [30:0]      arg_index,
  output logic [30:0]      arg_count,
  output logic [30:0]      command_bytes,
  output logic             arg_end,
  output logic             command_end,
  output logic [2:0]       command_class,
  output logic [2:0]       error_code
);
  import rrf_pkg::*;

  localparam int ACC_W = COUNT_BITS + 1;
  localparam int IDX_W = $clog2(NAME_BYTES);
  localparam int POS_W = $clog2(NAME_BYTES + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [ACC_W-1:0]      ACC_SAT = {1'b1, {COUNT_BITS{1'b0}}};

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;

  // parser state
  phase_t                  phase, phase_next;
  logic [ACC_W-1:0]        acc, acc_next;
  logic                    neg, neg_next;
  logic                    done, done_next;
  logic                    started, started_next;
  logic [COUNT_BITS-1:0]   args_left, args_left_next;
  logic [COUNT_BITS-1:0]   cur_arg, cur_arg_next;
  logic [COUNT_BITS-1:0]   pay_left, pay_left_next;
  logic [COUNT_BITS-1:0]   bcnt, bcnt_next;
  logic [COUNT_BITS-1:0]   name_len, name_len_next;
  logic [POS_W-1:0]        name_pos, name_pos_next;
  logic [NAME_BYTES-1:0][7:0] name;
  logic                    name_we;

  // step results
  logic [2:0]              r_role;
  logic [COUNT_BITS-1:0]   r_ai;
  logic [COUNT_BITS-1:0]   r_ac;
  logic [COUNT_BITS-1:0]   r_cb;
  logic                    r_ae;
  logic                    r_ce;
  logic [2:0]              r_cls;
  logic [2:0]              r_err;
  logic [2:0]              cls_now;

  // number feed
  logic                    is_digit;
  logic                    is_space;
  logic [ACC_W+3:0]        prod;
  logic [ACC_W-1:0]        f_acc;
  logic                    f_neg;
  logic                    f_done;
  logic                    f_started;
  logic                    line_lf;
  logic                    fail;
  logic                    to_idle;

  // handshake: the input register moves on whenever the result register frees
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (s1_valid && !advance) || (in_valid && !in_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= in_byte;
    end
  end

  rrf_classify #(
    .NAME_BYTES (NAME_BYTES),
    .LEN_BITS   (COUNT_BITS)
  ) u_classify (
    .name      (name),
    .name_len  (name_len),
    .cmd_class (cls_now)
  );

  // atoi-style digit accumulate with saturation one above the count limit
  always_comb begin
    is_digit  = (s1_byte >= CH_ZERO) && (s1_byte <= CH_NINE);
    is_space  = (s1_byte == CH_SPACE) || ((s1_byte >= CH_TAB) && (s1_byte <= CH_CR));
    prod      = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (ACC_W + 4)'(s1_byte[3:0]);
    f_acc     = acc;
    f_neg     = neg;
    f_done    = done;
    f_started = started;
    if (!done) begin
      if (!started && is_space) begin
        f_started = 1'b0;
      end else if (!started && (s1_byte == CH_PLUS || s1_byte == CH_MINUS)) begin
        f_started = 1'b1;
        f_neg     = (s1_byte == CH_MINUS);
      end else begin
        f_started = 1'b1;
        if (!is_digit) begin
          f_done = 1'b1;
        end else if (!acc[COUNT_BITS]) begin
          if (prod > (ACC_W + 4)'(CNT_MAX)) begin
            f_acc = ACC_SAT;
          end else begin
            f_acc = prod[ACC_W-1:0];
          end
        end
      end
    end
  end

  // one parser step for the byte in the input register
  always_comb begin
    phase_next     = phase;
    acc_next       = acc;
    neg_next       = neg;
    done_next      = done;
    started_next   = started;
    args_left_next = args_left;
    cur_arg_next   = cur_arg;
    pay_left_next  = pay_left;
    bcnt_next      = bcnt;
    name_len_next  = name_len;
    name_pos_next  = name_pos;
    name_we        = 1'b0;
    fail           = 1'b0;
    to_idle        = 1'b0;
    line_lf        = 1'b0;

    r_role = ROLE_DISCARD;
    r_ai   = '0;
    r_ac   = '0;
    r_cb   = '0;
    r_ae   = 1'b0;
    r_ce   = 1'b0;
    r_cls  = CLASS_OTHER;
    r_err  = ERR_NONE;

    if (phase == PH_IDLE) begin
      if (s1_byte == CH_STAR) begin
        to_idle    = 1'b1;
        r_role     = ROLE_ARRAY;
        r_cb       = COUNT_BITS'(1);
      end else begin
        r_err = ERR_NO_STAR;
      end
    end else begin
      if (bcnt != CNT_MAX) begin
        bcnt_next = bcnt + COUNT_BITS'(1);
      end
      r_cb = bcnt_next;
      r_ai = cur_arg;
      r_ac = args_left + cur_arg;

      case (phase)
        PH_CNT_TXT, PH_CNT_CR, PH_LEN_TXT, PH_LEN_CR: begin
          // number line: LF after CR closes it, anything else is line text
          if ((phase == PH_CNT_CR || phase == PH_LEN_CR) && s1_byte == CH_LF) begin
            r_role  = ROLE_CRLF;
            line_lf = 1'b1;
          end else begin
            acc_next     = f_acc;
            neg_next     = f_neg;
            done_next    = f_done;
            started_next = f_started;
            if (s1_byte == CH_CR) begin
              r_role     = ROLE_CRLF;
              phase_next = (phase == PH_CNT_TXT || phase == PH_CNT_CR) ?
                           PH_CNT_CR : PH_LEN_CR;
            end else begin
              r_role     = (phase == PH_CNT_TXT || phase == PH_CNT_CR) ?
                           ROLE_COUNT : ROLE_LENGTH;
              phase_next = (phase == PH_CNT_TXT || phase == PH_CNT_CR) ?
                           PH_CNT_TXT : PH_LEN_TXT;
            end
          end
          // count line complete
          if (line_lf && phase == PH_CNT_CR) begin
            if (acc[COUNT_BITS]) begin
              r_err = ERR_NUMBER;
              fail  = 1'b1;
            end else begin
              r_ac = neg ? '0 : acc[COUNT_BITS-1:0];
              if (neg || acc == '0) begin
                r_ce    = 1'b1;
                to_idle = 1'b1;
              end else begin
                args_left_next = acc[COUNT_BITS-1:0];
                cur_arg_next   = '0;
                phase_next     = PH_DOLLAR;
              end
            end
          end
          // length line complete
          if (line_lf && phase == PH_LEN_CR) begin
            if (acc[COUNT_BITS] || (neg && acc != '0)) begin
              r_err = ERR_NUMBER;
              fail  = 1'b1;
            end else begin
              pay_left_next = acc[COUNT_BITS-1:0];
              if (cur_arg == '0) begin
                name_len_next = acc[COUNT_BITS-1:0];
                name_pos_next = '0;
              end
              phase_next = (acc != '0) ? PH_PAYLOAD : PH_PAY_CR;
            end
          end
        end
        PH_DOLLAR: begin
          if (s1_byte == CH_DOLLAR) begin
            r_role       = ROLE_DOLLAR;
            acc_next     = '0;
            neg_next     = 1'b0;
            done_next    = 1'b0;
            started_next = 1'b0;
            phase_next   = PH_LEN_TXT;
          end else begin
            r_err = ERR_NO_DOLLAR;
            fail  = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          r_role = ROLE_PAYLOAD;
          // keep the leading bytes of the first argument
          if (cur_arg == '0 && name_pos < POS_W'(NAME_BYTES)) begin
            name_we       = 1'b1;
            name_pos_next = name_pos + POS_W'(1);
          end
          pay_left_next = pay_left - COUNT_BITS'(1);
          if (pay_left == COUNT_BITS'(1)) begin
            phase_next = PH_PAY_CR;
          end
        end
        PH_PAY_CR: begin
          if (s1_byte == CH_CR) begin
            r_role     = ROLE_CRLF;
            phase_next = PH_PAY_LF;
          end else begin
            r_err = ERR_NO_CRLF;
            fail  = 1'b1;
          end
        end
        PH_PAY_LF: begin
          if (s1_byte == CH_LF) begin
            r_role         = ROLE_CRLF;
            r_ae           = 1'b1;
            cur_arg_next   = cur_arg + COUNT_BITS'(1);
            args_left_next = args_left - COUNT_BITS'(1);
            if (args_left == COUNT_BITS'(1)) begin
              r_ce    = 1'b1;
              r_cls   = cls_now;
              to_idle = 1'b1;
            end else begin
              phase_next = PH_DOLLAR;
            end
          end else begin
            r_err = ERR_NO_CRLF;
            fail  = 1'b1;
          end
        end
        default: begin
          to_idle = 1'b1;
        end
      endcase

      if (fail) begin
        r_role  = ROLE_DISCARD;
        to_idle = 1'b1;
      end
    end

    // back to waiting for '*'; a fresh '*' starts the count line instead
    if (to_idle) begin
      phase_next     = PH_IDLE;
      args_left_next = '0;
      cur_arg_next   = '0;
      pay_left_next  = '0;
      bcnt_next      = '0;
      acc_next       = '0;
      neg_next       = 1'b0;
      done_next      = 1'b0;
      started_next   = 1'b0;
      if (phase == PH_IDLE) begin
        phase_next = PH_CNT_TXT;
        bcnt_next  = COUNT_BITS'(1);
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      acc       <= '0;
      neg       <= 1'b0;
      done      <= 1'b0;
      started   <= 1'b0;
      args_left <= '0;
      cur_arg   <= '0;
      pay_left  <= '0;
      bcnt      <= '0;
      name_len  <= '0;
      name_pos  <= '0;
    end else if (advance) begin
      phase     <= phase_next;
      acc       <= acc_next;
      neg       <= neg_next;
      done      <= done_next;
      started   <= started_next;
      args_left <= args_left_next;
      cur_arg   <= cur_arg_next;
      pay_left  <= pay_left_next;
      bcnt      <= bcnt_next;
      name_len  <= name_len_next;
      name_pos  <= name_pos_next;
    end
  end

  // first argument name store
  always_ff @(posedge clk) begin
    if (advance && name_we) begin
      name[name_pos[IDX_W-1:0]] <= s1_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_role     <= r_role;
      arg_index     <= 31'(r_ai);
      arg_count     <= 31'(r_ac);
      command_bytes <= 31'(r_cb);
      arg_end       <= r_ae;
      command_end   <= r_ce;
      command_class <= r_cls;
      error_code    <= r_err;
    end
  end

endmodule

`default_nettype wire

>>> src/rrf_checker.sv
// ============================================================================
// rrf_checker
// Port-level checks on the framer result stream, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rrf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  byte_role,
  input wire logic [30:0] arg_index,
  input wire logic [30:0] arg_count,
  input wire logic [30:0] command_bytes,
  input wire logic        arg_end,
  input wire logic        command_end,
  input wire logic [2:0]  command_class,
  input wire logic [2:0]  error_code
);
  import rrf_pkg::*;

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_byte))
    else $error("stalled input word changed");

  // a stalled result word holds its role, index, count, byte count, class and error code
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_role) &&
      $stable(arg_index) && $stable(arg_count) && $stable(command_bytes) &&
      $stable(command_class) && $stable(error_code))
    else $error("stalled result word changed");

  // an error byte is discarded and never closes anything
  a_err_discard: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |->
      byte_role == ROLE_DISCARD && !arg_end && !command_end)
    else $error("error byte not discarded");

  // a command ends only on a clean CR/LF byte
  a_end_crlf: assert property (@(posedge clk) disable iff (rst)
    out_valid && (command_end || arg_end) |->
      byte_role == ROLE_CRLF && error_code == ERR_NONE)
    else $error("end mark on wrong byte");

  // a class is reported only at command end
  a_class_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && command_class != CLASS_OTHER |-> command_end && arg_end)
    else $error("class outside command end");

endmodule

bind resp_request_framer_core rrf_checker u_rrf_checker (.*);

`default_nettype wire
